[src/tzhc_pkg.sv]
// Package for the three-zone heating controller.
// Holds field widths, zone and register codes, and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps

package tzhc_pkg;

    localparam int TEMP_W   = 15;
    localparam int DIFF_W   = 16;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 16;
    localparam int DB_W     = 10;
    localparam int HY_W     = 9;
    localparam int RATE_W   = 16;
    localparam int THR_W    = 17;
    localparam int DEN_W    = 31;
    localparam int DEN20_W  = 36;
    localparam int LH_W     = 33;
    localparam int NUM_W    = 42;
    localparam int REM_W    = 40;
    localparam int Q_W      = 10;
    localparam int CNT_W    = 4;
    localparam int VALVE_W  = 8;
    localparam int ZONE_W   = 2;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 16;

    localparam logic [CNT_W-1:0]   DIV_LAST_STEP = 4'd9;
    localparam logic [VALVE_W-1:0] VALVE_OPEN    = 8'd180;
    localparam logic [VALVE_W-1:0] VALVE_CLOSED  = 8'd0;

    localparam logic [ZONE_W-1:0] ZONE_COLD = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_EQ   = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_WARM = 2'd2;

    localparam logic [CFG_A_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_DBAND  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_HYST   = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_LOSS   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_GAIN   = 3'd4;

    typedef struct packed {
        logic load;
        logic mul_den;
        logic mul_lh;
        logic calc_num;
        logic div_step;
        logic out_write;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

[src/three_zone_heating_controller_unit.sv]
// Each item passes through the accept step, two multiply steps, one numerator step,
// ten steps of the restoring divider and the output write, which waits while the
// output register is busy; a new item is accepted only once the last one is written.
// A waiting result does not block the next item; only a second finished result waits.
// Reset (rst_n, asynchronous, active low) restores the settings and the equilibrium zone.
// Top level: joins tzhc_ctrl and tzhc_datapath; uses tzhc_pkg.
`timescale 1ns / 1ps

module three_zone_heating_controller_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tzhc_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [tzhc_pkg::CFG_D_W-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // home_temp [14:0], boiler_temp [29:15], outside_temp [44:30], zero fill [47:45]
    input  logic [tzhc_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pump_on [0], valve_angle [8:1], zone_now [10:9], zero fill [15:11]
    output logic [tzhc_pkg::OUT_W-1:0]    m_tdata
);

    tzhc_pkg::cmd_t cmd;
    tzhc_pkg::sts_t sts;

    tzhc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tzhc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[src/tzhc_ctrl.sv]
// Sequencing state machine of the three-zone heating controller.
// Steps the datapath through multiply, numerator and ten divide steps; uses tzhc_pkg.
`timescale 1ns / 1ps

module tzhc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output tzhc_pkg::cmd_t cmd,
    input  tzhc_pkg::sts_t sts
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL_DEN = 3'd1;
    localparam logic [2:0] S_MUL_LH  = 3'd2;
    localparam logic [2:0] S_NUM     = 3'd3;
    localparam logic [2:0] S_DIV     = 3'd4;
    localparam logic [2:0] S_FIN     = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [tzhc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_DEN;
                end
            end
            S_MUL_DEN:
            begin
                cmd.mul_den = 1'b1;
                state_next  = S_MUL_LH;
            end
            S_MUL_LH:
            begin
                cmd.mul_lh = 1'b1;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                cmd.calc_num = 1'b1;
                cnt_next     = tzhc_pkg::DIV_LAST_STEP;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The divider always runs its full count before a result is offered.
    a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_FIN))
        else $error("divider did not hand over to the finish step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_MUL_DEN))
        else $error("accepted transfer did not start the multiply step");

    a_fin_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_write |-> (state_reg == S_FIN && sts.out_free))
        else $error("result written while output register busy");

endmodule

[src/tzhc_datapath.sv]
// Datapath of the three-zone heating controller: settings, zone state,
// multipliers, restoring divider and output register. Uses tzhc_pkg.
`timescale 1ns / 1ps

module tzhc_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tzhc_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [tzhc_pkg::CFG_D_W-1:0]   cfg_wdata,
    input  logic [tzhc_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tzhc_pkg::OUT_W-1:0]     m_tdata,
    input  tzhc_pkg::cmd_t                 cmd,
    output tzhc_pkg::sts_t                 sts
);

    localparam logic signed [9:0] K200 = 10'sd200;
    localparam logic [4:0]        K20  = 5'd20;

    logic signed [tzhc_pkg::TEMP_W-1:0]  target_reg;
    logic [tzhc_pkg::DB_W-1:0]           dband_reg;
    logic [tzhc_pkg::HY_W-1:0]           hyst_reg;
    logic [tzhc_pkg::RATE_W-1:0]         loss_reg;
    logic [tzhc_pkg::RATE_W-1:0]         gain_reg;
    logic [tzhc_pkg::ZONE_W-1:0]         zone_reg, zone_next;

    logic signed [tzhc_pkg::DIFF_W-1:0]  dlt_reg, ho_reg;
    logic                                dpos_reg;
    logic [tzhc_pkg::DEN_W-1:0]          den_reg;
    logic [tzhc_pkg::DEN20_W-1:0]        den20_reg;
    logic signed [tzhc_pkg::LH_W-1:0]    lh_reg;
    logic                                npos_reg;
    logic [tzhc_pkg::REM_W-1:0]          rem_reg, dsh_reg;
    logic [tzhc_pkg::Q_W-1:0]            q_reg;

    logic                                out_valid_reg;
    logic                                pump_reg;
    logic [tzhc_pkg::VALVE_W-1:0]        valve_reg;
    logic [tzhc_pkg::ZONE_W-1:0]         zout_reg;

    logic signed [tzhc_pkg::TEMP_W-1:0]  home_w, boiler_w, outside_w;
    logic signed [tzhc_pkg::THR_W-1:0]   home_x, tgt_x, db_x, hy_x;
    logic signed [tzhc_pkg::DIFF_W-1:0]  dlt_next;
    logic signed [tzhc_pkg::NUM_W-1:0]   num_w;
    logic                                pump_w;
    logic [tzhc_pkg::VALVE_W-1:0]        valve_w;

    assign home_w    = s_tdata[14:0];
    assign boiler_w  = s_tdata[29:15];
    assign outside_w = s_tdata[44:30];
    assign home_x    = {{2{home_w[14]}}, home_w};
    assign tgt_x     = {{2{target_reg[14]}}, target_reg};
    assign db_x      = {7'b0, dband_reg};
    assign hy_x      = {8'b0, hyst_reg};
    assign dlt_next  = {boiler_w[14], boiler_w} - {home_w[14], home_w};

    always_comb
    begin
        zone_next = zone_reg;
        priority if (zone_reg == tzhc_pkg::ZONE_COLD && home_x > tgt_x - db_x + hy_x)
            zone_next = tzhc_pkg::ZONE_EQ;
        else if (zone_reg == tzhc_pkg::ZONE_WARM && home_x < tgt_x + db_x - hy_x)
            zone_next = tzhc_pkg::ZONE_EQ;
        else if (zone_reg == tzhc_pkg::ZONE_EQ && home_x < tgt_x - db_x - hy_x)
            zone_next = tzhc_pkg::ZONE_COLD;
        else if (zone_reg == tzhc_pkg::ZONE_EQ && home_x > tgt_x + db_x + hy_x)
            zone_next = tzhc_pkg::ZONE_WARM;
        else
            zone_next = zone_reg;
    end

    assign num_w = lh_reg * K200 - $signed({6'b0, den20_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 15'sd2100;
            dband_reg  <= 10'd50;
            hyst_reg   <= 9'd10;
            loss_reg   <= 16'd100;
            gain_reg   <= 16'd500;
            zone_reg   <= tzhc_pkg::ZONE_EQ;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    tzhc_pkg::REG_TARGET: target_reg <= cfg_wdata[14:0];
                    tzhc_pkg::REG_DBAND:  dband_reg  <= cfg_wdata[9:0];
                    tzhc_pkg::REG_HYST:   hyst_reg   <= cfg_wdata[8:0];
                    tzhc_pkg::REG_LOSS:   loss_reg   <= cfg_wdata;
                    tzhc_pkg::REG_GAIN:   gain_reg   <= cfg_wdata;
                    default:              ;
                endcase
            end
            if (cmd.load)
            begin
                zone_reg <= zone_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dlt_reg  <= dlt_next;
            dpos_reg <= !dlt_next[15] && (dlt_next != '0);
            ho_reg   <= {home_w[14], home_w} - {outside_w[14], outside_w};
        end
        if (cmd.mul_den)
        begin
            den_reg <= gain_reg * dlt_reg[14:0];
        end
        if (cmd.mul_lh)
        begin
            den20_reg <= den_reg * K20;
            lh_reg    <= $signed({1'b0, loss_reg}) * ho_reg;
        end
        if (cmd.calc_num)
        begin
            npos_reg <= !num_w[tzhc_pkg::NUM_W-1] && (num_w != '0);
            rem_reg  <= num_w[tzhc_pkg::REM_W-1:0];
            dsh_reg  <= {den_reg, 9'b0};
            q_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[tzhc_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                q_reg   <= {q_reg[tzhc_pkg::Q_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_comb
    begin
        pump_w  = 1'b1;
        valve_w = tzhc_pkg::VALVE_CLOSED;
        unique case (zone_reg)
            tzhc_pkg::ZONE_COLD:
            begin
                valve_w = tzhc_pkg::VALVE_OPEN;
            end
            tzhc_pkg::ZONE_WARM:
            begin
                pump_w = 1'b0;
            end
            default:
            begin
                if (!dpos_reg || gain_reg == '0 || !npos_reg)
                    valve_w = tzhc_pkg::VALVE_CLOSED;
                else if (q_reg > {2'b0, tzhc_pkg::VALVE_OPEN})
                    valve_w = tzhc_pkg::VALVE_OPEN;
                else
                    valve_w = q_reg[tzhc_pkg::VALVE_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_write)
        begin
            pump_reg  <= pump_w;
            valve_reg <= valve_w;
            zout_reg  <= zone_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {5'b0, zout_reg, valve_reg, pump_reg};

    a_valve_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (valve_reg <= tzhc_pkg::VALVE_OPEN))
        else $error("valve angle beyond full open");

    a_cold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && zout_reg == tzhc_pkg::ZONE_COLD)
            |-> (pump_reg && valve_reg == tzhc_pkg::VALVE_OPEN))
        else $error("cold zone result without full heating");

    a_warm_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && zout_reg == tzhc_pkg::ZONE_WARM)
            |-> (!pump_reg && valve_reg == tzhc_pkg::VALVE_CLOSED))
        else $error("warm zone result with heating on");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the three-zone heating controller unit.
// Streams temperature samples, writes the settings between phases and checks every result.
// Depends on tzhc_pkg and three_zone_heating_controller_unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 5;
    localparam int IDLE_LIMIT       = 3000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int NUM_ROWS         = 17;
    localparam int NUM_PHASES       = 10;
    localparam int SAMPLES_PER_PHASE = 124;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int HOLD_OFF_AFTER   = 300;

    typedef struct packed {
        logic                         pump;
        logic [tzhc_pkg::VALVE_W-1:0] valve;
        logic [tzhc_pkg::ZONE_W-1:0]  zone;
    } heat_cmd_t;

    typedef struct packed {
        int                           home;
        int                           boiler;
        int                           outside;
        bit                           typed;
        bit                           pump;
        logic [tzhc_pkg::VALVE_W-1:0] valve;
        logic [tzhc_pkg::ZONE_W-1:0]  zone;
    } sample_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [tzhc_pkg::CFG_A_W-1:0]  cfg_addr;
    logic [tzhc_pkg::CFG_D_W-1:0]  cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [tzhc_pkg::IN_W-1:0]     s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [tzhc_pkg::OUT_W-1:0]    m_tdata;

    // Local copy of the settings, updated as they are written, and of the zone, updated as transfers are accepted.
    longint                        set_target;
    longint                        set_dband;
    longint                        set_hyst;
    longint                        set_loss;
    longint                        set_gain;
    logic [tzhc_pkg::ZONE_W-1:0]   zone_state;

    heat_cmd_t           heating_expected[$];
    sample_row_t         dir_rows [NUM_ROWS];
    int                  mismatches;
    int                  results_seen;
    int                  idle_cycles;
    int                  burst_left;

    three_zone_heating_controller_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic heat_cmd_t predict_heating(logic [tzhc_pkg::TEMP_W-1:0] home_raw,
                                                  logic [tzhc_pkg::TEMP_W-1:0] boiler_raw,
                                                  logic [tzhc_pkg::TEMP_W-1:0] outside_raw);
        longint    home;
        longint    boiler;
        longint    outside;
        longint    rise;
        longint    den;
        longint    num;
        longint    angle;
        heat_cmd_t cmd;
        home    = longint'($signed(home_raw));
        boiler  = longint'($signed(boiler_raw));
        outside = longint'($signed(outside_raw));

        if (zone_state == tzhc_pkg::ZONE_COLD && home > set_target - set_dband + set_hyst)
            zone_state = tzhc_pkg::ZONE_EQ;
        else if (zone_state == tzhc_pkg::ZONE_WARM
                 && home < set_target + set_dband - set_hyst)
            zone_state = tzhc_pkg::ZONE_EQ;
        else if (zone_state == tzhc_pkg::ZONE_EQ && home < set_target - set_dband - set_hyst)
            zone_state = tzhc_pkg::ZONE_COLD;
        else if (zone_state == tzhc_pkg::ZONE_EQ && home > set_target + set_dband + set_hyst)
            zone_state = tzhc_pkg::ZONE_WARM;

        // The balance angle is (200*loss*(home-outside) - 20*den) / den, den = gain*rise, capped at full open.
        rise  = boiler - home;
        angle = 0;
        if (rise > 0 && set_gain != 0)
        begin
            den = set_gain * rise;
            num = 200 * set_loss * (home - outside) - 20 * den;
            if (num > 0)
                angle = num / den;
            if (angle > longint'(tzhc_pkg::VALVE_OPEN))
                angle = longint'(tzhc_pkg::VALVE_OPEN);
        end

        cmd.zone = zone_state;
        case (zone_state)
            tzhc_pkg::ZONE_COLD:
            begin
                cmd.pump  = 1'b1;
                cmd.valve = tzhc_pkg::VALVE_OPEN;
            end
            tzhc_pkg::ZONE_WARM:
            begin
                cmd.pump  = 1'b0;
                cmd.valve = tzhc_pkg::VALVE_CLOSED;
            end
            default:
            begin
                cmd.pump  = 1'b1;
                cmd.valve = angle[tzhc_pkg::VALVE_W-1:0];
            end
        endcase
        return cmd;
    endfunction

    task automatic idle_sender(int cycles);
        logic [63:0] noise;
        repeat (cycles)
        begin
            @(negedge clk);
            noise     = {$urandom, $urandom};
            s_tvalid <= 1'b0;
            s_tdata  <= noise[tzhc_pkg::IN_W-1:0];
        end
    endtask

    task automatic send_sample(logic [tzhc_pkg::TEMP_W-1:0] home,
                               logic [tzhc_pkg::TEMP_W-1:0] boiler,
                               logic [tzhc_pkg::TEMP_W-1:0] outside,
                               bit typed, heat_cmd_t want);
        heat_cmd_t predicted;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 20));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(tzhc_pkg::IN_W - 3 * tzhc_pkg::TEMP_W){1'b0}}, outside, boiler, home};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_heating(home, boiler, outside);
        heating_expected.push_back(typed ? want : predicted);
    endtask

    task automatic send_random_sample();
        int home;
        int boiler;
        int outside;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        span = int'(set_dband + set_hyst) + 40;
        if (kind == 0)
        begin
            home    = $urandom;
            boiler  = $urandom;
            outside = $urandom;
        end
        else if (kind <= 7)
        begin
            // Most samples sit around the zone boundaries so that the zone keeps moving.
            home    = int'(set_target) + int'($urandom_range(0, 2 * span)) - span;
            boiler  = home + int'($urandom_range(0, 4000)) - 200;
            outside = home - int'($urandom_range(0, 3000)) + 300;
        end
        else
        begin
            home    = int'($urandom_range(0, 20000)) - 5000;
            boiler  = int'($urandom_range(0, 20000)) - 5000;
            outside = int'($urandom_range(0, 20000)) - 5000;
        end
        send_sample(home[tzhc_pkg::TEMP_W-1:0], boiler[tzhc_pkg::TEMP_W-1:0],
                    outside[tzhc_pkg::TEMP_W-1:0], 1'b0, '0);
    endtask

    task automatic write_setting(logic [tzhc_pkg::CFG_A_W-1:0] index,
                                 logic [tzhc_pkg::CFG_D_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        case (index)
            tzhc_pkg::REG_TARGET:
                set_target = longint'($signed(value[tzhc_pkg::TEMP_W-1:0]));
            tzhc_pkg::REG_DBAND:  set_dband = longint'(value[tzhc_pkg::DB_W-1:0]);
            tzhc_pkg::REG_HYST:   set_hyst  = longint'(value[tzhc_pkg::HY_W-1:0]);
            tzhc_pkg::REG_LOSS:   set_loss  = longint'(value[tzhc_pkg::RATE_W-1:0]);
            tzhc_pkg::REG_GAIN:   set_gain  = longint'(value[tzhc_pkg::RATE_W-1:0]);
            default:              ;
        endcase
    endtask

    task automatic program_settings(int target, int dband, int hyst, int loss, int gain,
                                    bit junk);
        logic [tzhc_pkg::CFG_D_W-1:0] extra;
        logic [31:0]                  noise;
        idle_sender(1);
        while (heating_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        // Bits above a register's width are don't-care and get random values here when junk is set.
        noise = $urandom;
        extra = junk ? noise[tzhc_pkg::CFG_D_W-1:0] : '0;
        write_setting(tzhc_pkg::REG_TARGET,
                      {extra[tzhc_pkg::CFG_D_W-1], target[tzhc_pkg::TEMP_W-1:0]});
        write_setting(tzhc_pkg::REG_DBAND,
                      {extra[tzhc_pkg::CFG_D_W-1:tzhc_pkg::DB_W], dband[tzhc_pkg::DB_W-1:0]});
        write_setting(tzhc_pkg::REG_HYST,
                      {extra[tzhc_pkg::CFG_D_W-1:tzhc_pkg::HY_W], hyst[tzhc_pkg::HY_W-1:0]});
        write_setting(tzhc_pkg::REG_LOSS, loss[tzhc_pkg::RATE_W-1:0]);
        write_setting(tzhc_pkg::REG_GAIN, gain[tzhc_pkg::RATE_W-1:0]);
        @(negedge clk);
        cfg_we     <= 1'b0;
        burst_left  = 0;
    endtask

    task automatic report_field(string field, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        heat_cmd_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (heating_expected.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got 0x%0h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = heating_expected.pop_front();
                report_field("pump_on", want.pump, m_tdata[0]);
                report_field("valve_angle", want.valve, m_tdata[tzhc_pkg::VALVE_W:1]);
                report_field("zone_now", want.zone,
                             m_tdata[tzhc_pkg::VALVE_W+tzhc_pkg::ZONE_W:tzhc_pkg::VALVE_W+1]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int  mode;
        int  span;
        bit  held;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && results_seen >= HOLD_OFF_AFTER)
            begin
                // One long hold-off lets the unit fill up and push back on its input.
                held = 1'b1;
                repeat (HOLD_OFF_CYCLES)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 100);
                repeat (span)
                begin
                    @(negedge clk);
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 1) == 0);
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        int        row;
        int        phase;
        int        count;
        heat_cmd_t want;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = tzhc_pkg::REG_TARGET;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        mismatches   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        set_target   = 2100;
        set_dband    = 50;
        set_hyst     = 10;
        set_loss     = 100;
        set_gain     = 500;
        zone_state   = tzhc_pkg::ZONE_EQ;

        // With the reset settings the zone leaves equilibrium below 2040 and above 2160,
        // and returns from cold above 2060 and from warm below 2140.
        dir_rows = '{
            '{2100, 2100, 0, 1'b1, 1'b1, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ},
            '{2100, 6000, 0, 1'b0, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ},
            '{2040, 6000, 0, 1'b0, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ},
            '{2039, 6000, 0, 1'b1, 1'b1, tzhc_pkg::VALVE_OPEN, tzhc_pkg::ZONE_COLD},
            '{2060, 2000, 0, 1'b1, 1'b1, tzhc_pkg::VALVE_OPEN, tzhc_pkg::ZONE_COLD},
            '{2061, 6000, -5000, 1'b0, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ},
            '{2160, 15000, -5000, 1'b0, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ},
            '{2161, 15000, -5000, 1'b1, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_WARM},
            '{2140, 6000, 0, 1'b1, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_WARM},
            '{15000, 15000, 15000, 1'b1, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_WARM},
            '{2139, 2200, 2100, 1'b0, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ},
            '{-16384, 16383, 16383, 1'b1, 1'b1, tzhc_pkg::VALVE_OPEN, tzhc_pkg::ZONE_COLD},
            '{16383, -16384, -16384, 1'b1, 1'b1, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ},
            '{16383, 16383, -16384, 1'b1, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_WARM},
            '{-5000, 16383, 16383, 1'b1, 1'b1, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ},
            '{2100, 16383, -16384, 1'b0, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ},
            '{2100, 2101, -16384, 1'b0, 1'b0, tzhc_pkg::VALVE_CLOSED, tzhc_pkg::ZONE_EQ}
        };

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < NUM_ROWS; row++)
        begin
            want.pump  = dir_rows[row].pump;
            want.valve = dir_rows[row].valve;
            want.zone  = dir_rows[row].zone;
            send_sample(dir_rows[row].home[tzhc_pkg::TEMP_W-1:0],
                        dir_rows[row].boiler[tzhc_pkg::TEMP_W-1:0],
                        dir_rows[row].outside[tzhc_pkg::TEMP_W-1:0],
                        dir_rows[row].typed, want);
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       ;
                1:       program_settings(-5000, 0, 0, 0, 1, 1'b0);
                2:       program_settings(15000, 1000, 500, 65535, 65535, 1'b0);
                3:       program_settings(2100, 300, 200, 100, 0, 1'b0);
                4:       program_settings(-16384, 1023, 511, 65535, 1, 1'b0);
                5:       program_settings(16383, 0, 511, 1, 65535, 1'b0);
                default: program_settings(int'($urandom_range(0, 20000)) - 5000,
                                          $urandom_range(0, 1000), $urandom_range(0, 500),
                                          ($urandom_range(0, 1) == 0) ?
                                              $urandom_range(0, 65535) :
                                              $urandom_range(1, 1000),
                                          ($urandom_range(0, 1) == 0) ?
                                              $urandom_range(0, 65535) :
                                              $urandom_range(1, 2000),
                                          1'b1);
            endcase
            for (count = 0; count < SAMPLES_PER_PHASE; count++)
                send_random_sample();
        end

        idle_sender(1);
        while (heating_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[three_zone_heating_controller_unit.f]
src/tzhc_pkg.sv
src/tzhc_ctrl.sv
src/tzhc_datapath.sv
src/three_zone_heating_controller_unit.sv
tb/tb_top.sv
